/* rtl/cbb_pkg.sv */
// Shared types, codes and reset constants for the circuit breaker with backoff.
// No dependencies; imported by every module of the block.
`default_nettype none

package cbb_pkg;

    localparam int TIME_W   = 48;
    localparam int CNT_W    = 32;
    localparam int PROBE_W  = 8;
    localparam int TRIP_W   = 16;
    localparam int CLOSE_W  = 8;
    localparam int MS_W     = 32;
    localparam int FACTOR_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int BACKOFF_EXP_CAP_DEF = 10;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 176;

    // Result field offsets inside m_tdata
    localparam int O_ALLOWED   = 0;
    localparam int O_MODE      = 1;
    localparam int O_FAIL_RUN  = 3;
    localparam int O_SUCC_RUN  = 35;
    localparam int O_PROBES    = 67;
    localparam int O_ATTEMPTS  = 75;
    localparam int O_SUCC_TOT  = 107;
    localparam int O_FAIL_TOT  = 139;
    localparam int O_END       = 171;

    localparam logic [TRIP_W-1:0]   TRIP_RST   = 16'd5;
    localparam logic [PROBE_W-1:0]  PROBE_RST  = 8'd3;
    localparam logic [CLOSE_W-1:0]  CLOSE_RST  = 8'd2;
    localparam logic [MS_W-1:0]     BASE_RST   = 32'd30000;
    localparam logic [MS_W-1:0]     MAX_RST    = 32'd300000;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 3'd2;

    localparam logic [CNT_W-1:0] CNT_SAT = '1;

    typedef enum logic [1:0] {
        MODE_CLOSED = 2'd0,
        MODE_OPEN   = 2'd1,
        MODE_HALF   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REQ_PERMIT  = 2'd0,
        REQ_SUCCESS = 2'd1,
        REQ_FAILURE = 2'd2,
        REQ_RESET   = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIP   = 3'd0,
        CFG_PROBE  = 3'd1,
        CFG_CLOSE  = 3'd2,
        CFG_BASE   = 3'd3,
        CFG_MAX    = 3'd4,
        CFG_FACTOR = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [TRIP_W-1:0]   trip_threshold;
        logic [PROBE_W-1:0]  probe_limit;
        logic [CLOSE_W-1:0]  close_threshold;
        logic [MS_W-1:0]     base_timeout_ms;
        logic [MS_W-1:0]     max_timeout_ms;
        logic [FACTOR_W-1:0] backoff_factor;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } wait_stat_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_SAT) ? v : v + CNT_W'(1);
    endfunction

endpackage

`default_nettype wire

/* rtl/cbb_cfg.sv */
// Configuration register bank for the circuit breaker.
// Depends on cbb_pkg for register codes, widths and reset values.
`default_nettype none

module cbb_cfg
    import cbb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trip_threshold  <= TRIP_RST;
            cfg_reg.probe_limit     <= PROBE_RST;
            cfg_reg.close_threshold <= CLOSE_RST;
            cfg_reg.base_timeout_ms <= BASE_RST;
            cfg_reg.max_timeout_ms  <= MAX_RST;
            cfg_reg.backoff_factor  <= FACTOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TRIP:   cfg_reg.trip_threshold  <= cfg_wdata[TRIP_W-1:0];
                CFG_PROBE:  cfg_reg.probe_limit     <= cfg_wdata[PROBE_W-1:0];
                CFG_CLOSE:  cfg_reg.close_threshold <= cfg_wdata[CLOSE_W-1:0];
                CFG_BASE:   cfg_reg.base_timeout_ms <= cfg_wdata[MS_W-1:0];
                CFG_MAX:    cfg_reg.max_timeout_ms  <= cfg_wdata[MS_W-1:0];
                CFG_FACTOR: cfg_reg.backoff_factor  <= cfg_wdata[FACTOR_W-1:0];
                default:    ; // drop writes beyond the register list
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/cbb_wait_unit.sv */
// Iterative backoff unit: one clamped multiply by the backoff factor per cycle.
// Depends on cbb_pkg for the configuration struct and status struct.
`default_nettype none

module cbb_wait_unit
    import cbb_pkg::*;
#(
    parameter int EXP_CAP = BACKOFF_EXP_CAP_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [CNT_W-1:0] fail_run,
    input  wire cfg_t             cfg,
    output wait_stat_t            stat,
    output logic      [MS_W-1:0]  wait_ms
);

    localparam int CW = $clog2(EXP_CAP + 1);
    localparam logic [CW-1:0] CAP_W = CW'(EXP_CAP);
    localparam int PROD_W = MS_W + FACTOR_W;

    logic [MS_W-1:0]   t_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic [CW-1:0]     exp_val;
    logic [MS_W-1:0]   t_first;
    logic [PROD_W-1:0] prod;
    logic [MS_W-1:0]   t_next;

    assign exp_val = (fail_run < CNT_W'(EXP_CAP)) ? fail_run[CW-1:0] : CAP_W;
    assign t_first = (cfg.base_timeout_ms > cfg.max_timeout_ms) ? cfg.max_timeout_ms
                                                                : cfg.base_timeout_ms;
    assign prod    = PROD_W'(t_reg) * PROD_W'(cfg.backoff_factor);
    // clamp after every multiply so the product never outgrows the unit
    assign t_next  = (prod > PROD_W'(cfg.max_timeout_ms)) ? cfg.max_timeout_ms
                                                          : prod[MS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= exp_val;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            t_reg <= t_first;
        else if (busy_reg && cnt_reg != '0)
            t_reg <= t_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == '0);
    assign wait_ms   = t_reg;

endmodule

`default_nettype wire

/* rtl/circuit_breaker_backoff.sv */
// Circuit breaker with exponential backoff: sequencer, breaker state and result register.
// Depends on cbb_pkg, cbb_cfg and cbb_wait_unit.
// Flow: IDLE accepts an item; EXEC commits it to the result register once the output is
// free. A permission request while open passes WAIT first: e = min(failure_run,
// BACKOFF_EXP_CAP) backoff multiplies, one per cycle. A new item is taken only in IDLE.
// Reset: asynchronous, active low; breaker closed, counters zero, registers at defaults.
`default_nettype none

module circuit_breaker_backoff
    import cbb_pkg::*;
#(
    parameter int BACKOFF_EXP_CAP = BACKOFF_EXP_CAP_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [47:0] now_ms
    input  wire logic [S_TUSER_W-1:0]  s_tuser,   // [1:0] req_type
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] allowed, [2:1] breaker_mode, [34:3] failure_run, [66:35] success_run,
    // [74:67] probes_used, [106:75] attempts_total, [138:107] successes_total,
    // [170:139] failures_total, [175:171] zero
    output logic [M_TDATA_W-1:0]       m_tdata,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WAIT = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t state_reg, state_next;

    cfg_t       cfg;
    wait_stat_t wstat;
    logic [MS_W-1:0] wait_ms;
    logic wait_start;

    mode_t              mode_reg, mode_next;
    logic [CNT_W-1:0]   fail_run_reg, fail_run_next;
    logic [CNT_W-1:0]   succ_run_reg, succ_run_next;
    logic [PROBE_W-1:0] probe_reg, probe_next;
    logic [TIME_W-1:0]  last_fail_reg, last_fail_next;
    logic [CNT_W-1:0]   att_tot_reg, att_tot_next;
    logic [CNT_W-1:0]   succ_tot_reg, succ_tot_next;
    logic [CNT_W-1:0]   fail_tot_reg, fail_tot_next;

    req_t              kind_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] elapsed_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic accept;
    logic commit;
    logic allowed;
    logic wait_ok;
    logic [CNT_W-1:0] fail_inc;
    logic [CNT_W-1:0] succ_inc;

    cbb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cbb_wait_unit #(
        .EXP_CAP (BACKOFF_EXP_CAP)
    ) u_wait (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (wait_start),
        .fail_run (fail_run_reg),
        .cfg      (cfg),
        .stat     (wstat),
        .wait_ms  (wait_ms)
    );

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign wait_start = accept && (req_t'(s_tuser) == REQ_PERMIT) && (mode_reg == MODE_OPEN);
    assign commit     = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = wait_start ? S_WAIT : S_EXEC;
            end
            S_WAIT:
            begin
                if (wstat.done)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (commit)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign wait_ok  = elapsed_reg >= TIME_W'(wait_ms);
    assign fail_inc = sat_inc(fail_run_reg);
    assign succ_inc = sat_inc(succ_run_reg);

    always_comb
    begin
        mode_next      = mode_reg;
        fail_run_next  = fail_run_reg;
        succ_run_next  = succ_run_reg;
        probe_next     = probe_reg;
        last_fail_next = last_fail_reg;
        att_tot_next   = att_tot_reg;
        succ_tot_next  = succ_tot_reg;
        fail_tot_next  = fail_tot_reg;
        allowed        = 1'b0;
        unique case (kind_reg)
            REQ_PERMIT:
            begin
                att_tot_next = sat_inc(att_tot_reg);
                if (mode_reg == MODE_CLOSED)
                    allowed = 1'b1;
                else if (mode_reg == MODE_OPEN)
                begin
                    if (wait_ok)
                    begin
                        mode_next     = MODE_HALF;
                        probe_next    = '0;
                        succ_run_next = '0;
                        allowed       = 1'b1;
                    end
                end
                else if (probe_reg < cfg.probe_limit)
                begin
                    probe_next = probe_reg + PROBE_W'(1);
                    allowed    = 1'b1;
                end
            end
            REQ_SUCCESS:
            begin
                succ_run_next = succ_inc;
                succ_tot_next = sat_inc(succ_tot_reg);
                if (mode_reg == MODE_CLOSED)
                    fail_run_next = '0;
                else if (mode_reg == MODE_HALF && succ_inc >= CNT_W'(cfg.close_threshold))
                begin
                    mode_next     = MODE_CLOSED;
                    fail_run_next = '0;
                    succ_run_next = '0;
                    probe_next    = '0;
                end
            end
            REQ_FAILURE:
            begin
                fail_run_next  = fail_inc;
                fail_tot_next  = sat_inc(fail_tot_reg);
                last_fail_next = now_reg;
                if ((mode_reg == MODE_CLOSED && fail_inc >= CNT_W'(cfg.trip_threshold))
                    || mode_reg == MODE_HALF)
                begin
                    mode_next     = MODE_OPEN;
                    succ_run_next = '0;
                    probe_next    = '0;
                end
            end
            REQ_RESET:
            begin
                mode_next     = MODE_CLOSED;
                fail_run_next = '0;
                succ_run_next = '0;
                probe_next    = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_CLOSED;
            fail_run_reg  <= '0;
            succ_run_reg  <= '0;
            probe_reg     <= '0;
            last_fail_reg <= '0;
            att_tot_reg   <= '0;
            succ_tot_reg  <= '0;
            fail_tot_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                mode_reg      <= mode_next;
                fail_run_reg  <= fail_run_next;
                succ_run_reg  <= succ_run_next;
                probe_reg     <= probe_next;
                last_fail_reg <= last_fail_next;
                att_tot_reg   <= att_tot_next;
                succ_tot_reg  <= succ_tot_next;
                fail_tot_reg  <= fail_tot_next;
                m_tvalid_reg  <= 1'b1;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Hold the item; elapsed time wraps modulo 2^48
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= req_t'(s_tuser);
            now_reg     <= s_tdata[TIME_W-1:0];
            elapsed_reg <= s_tdata[TIME_W-1:0] - last_fail_reg;
        end
        if (commit)
            m_tdata_reg <= {{(M_TDATA_W-O_END){1'b0}}, fail_tot_next, succ_tot_next,
                            att_tot_next, probe_next, succ_run_next, fail_run_next,
                            mode_next, allowed};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted item did not start the sequencer");

    a_wait_unit_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) == wstat.busy)
        else $error("backoff unit busy outside the wait phase");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_EXEC))
        else $error("result appeared without a commit");

endmodule

`default_nettype wire
